/* hdl/bitmap_video_pixel_shifter_assert.svh */
// Assertion macros for the bitmap video pixel shifter checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef BITMAP_VIDEO_PIXEL_SHIFTER_ASSERT_SVH
`define BITMAP_VIDEO_PIXEL_SHIFTER_ASSERT_SVH

// same-cycle implication
`define BVPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BVPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/bvps_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and pixel color function for the pixel shifter.
// No dependencies.
package bvps_pkg;

	localparam int VIDEO_DEPTH     = 8192;
	localparam int COLOR_MAP_DEPTH = 1024;
	localparam int PIXELS_PER_CELL = 8;
	localparam int QUEUE_DEPTH     = 4;

	localparam int VIDEO_AW = $clog2(VIDEO_DEPTH);
	localparam int COLOR_AW = $clog2(COLOR_MAP_DEPTH);
	localparam int IDX_W    = $clog2(PIXELS_PER_CELL);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 1;

	localparam logic [1:0] REQ_VIDEO_WR = 2'd0;
	localparam logic [1:0] REQ_COLOR_WR = 2'd1;
	localparam logic [1:0] REQ_RENDER   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BANK_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BANK_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP      = 2'd2;

	localparam logic [7:0] LEVEL_ON   = 8'haa;
	localparam logic [7:0] LEVEL_FULL = 8'hff;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [12:0] mem_addr;
		logic [7:0]  mem_data;
		logic [13:0] cell_addr;
		logic [4:0]  row_addr;
	} in_t;

	typedef struct packed {
		logic [3:0] pen;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} out_t;

	// one fetched cell: pixel byte already in shift order, selected nibble
	typedef struct packed {
		logic [PIXELS_PER_CELL-1:0] pixels;
		logic [3:0]                 color;
	} cell_t;

	typedef struct packed {
		logic full;
		logic almost_full;
	} q_stat_t;

	function automatic out_t make_pixel(logic [3:0] color, logic bit_on, logic last);
		out_t       o;
		logic [3:0] pen;
		pen = bit_on ? color : {color[3], 3'b000};
		o.pen = pen;
		o.red = (pen[3] && (pen[2:0] != 3'b000)) ? LEVEL_FULL : (pen[0] ? LEVEL_ON : 8'h00);
		o.green = pen[1] ? LEVEL_ON : 8'h00;
		o.blue = pen[2] ? LEVEL_ON : 8'h00;
		o.last_pixel = last;
		return o;
	endfunction

endpackage

/* hdl/bvps_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bvps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/bvps_front.sv */
`timescale 1ns / 1ps
// Front end: config registers, item intake, memory writes and cell fetch.
// Depends on bvps_pkg and bvps_ram.
module bvps_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  bvps_pkg::in_t                    in_data,
	input  logic                             cfg_we,
	input  logic [bvps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bvps_pkg::CFG_W-1:0]       cfg_data,
	input  bvps_pkg::q_stat_t                q_stat,
	output logic                             push,
	output bvps_pkg::cell_t                  push_cell
);
	import bvps_pkg::*;

	logic bank_low_q, bank_high_q, flip_q;
	logic valid_s1, flip_s1;
	logic accept;
	logic [13:0] m;
	logic rb;
	logic [VIDEO_AW-1:0] vaddr, caddr_full;
	logic [COLOR_AW-1:0] cidx;
	logic [7:0] vdata, cdata;

	function automatic logic [7:0] rev8(logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	// with a fetch in flight, keep a second slot free for it
	assign in_stall = valid_s1 ? q_stat.almost_full : q_stat.full;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_low_q <= 1'b0;
			bank_high_q <= 1'b0;
			flip_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BANK_LOW: bank_low_q <= cfg_data[0];
				CFG_BANK_HIGH: bank_high_q <= cfg_data[0];
				CFG_FLIP: flip_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// flip mode works on the inverted CRTC address and row bit
	assign m = flip_q ? ~in_data.cell_addr : in_data.cell_addr;
	assign rb = in_data.row_addr[0] ^ flip_q;
	assign vaddr = {m[11:5], rb, m[4:0]};
	assign caddr_full = flip_q ? ~vaddr : vaddr;
	assign cidx = {bank_high_q, bank_low_q, caddr_full[12:9], caddr_full[4:1]};

	bvps_ram #(.WIDTH(8), .DEPTH(VIDEO_DEPTH)) u_video (
		.clk   (clk),
		.we    (accept && (in_data.req_type == REQ_VIDEO_WR)),
		.waddr (in_data.mem_addr),
		.wdata (in_data.mem_data),
		.raddr (vaddr),
		.rdata (vdata)
	);

	bvps_ram #(.WIDTH(8), .DEPTH(COLOR_MAP_DEPTH)) u_color (
		.clk   (clk),
		.we    (accept && (in_data.req_type == REQ_COLOR_WR)),
		.waddr (in_data.mem_addr[COLOR_AW-1:0]),
		.wdata (in_data.mem_data),
		.raddr (cidx),
		.rdata (cdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (in_data.req_type == REQ_RENDER);
		end
	end

	always_ff @(posedge clk) begin
		flip_s1 <= flip_q;
	end

	// flip shifts LSB first: reverse so the back end always takes bit 7 first
	assign push = valid_s1;
	assign push_cell.pixels = flip_s1 ? rev8(vdata) : vdata;
	assign push_cell.color = flip_s1 ? cdata[7:4] : cdata[3:0];

endmodule

/* hdl/bvps_queue.sv */
`timescale 1ns / 1ps
// Small queue of fetched cells between front and back ends.
// Depends on bvps_pkg.
module bvps_queue #(
	parameter int DEPTH = bvps_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bvps_pkg::cell_t   push_cell,
	input  logic              pop,
	output logic              q_valid,
	output bvps_pkg::cell_t   q_cell,
	output bvps_pkg::q_stat_t q_stat
);
	import bvps_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cell_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_pop;

	assign q_valid = (count_q != '0);
	assign q_cell = mem_q[rd_ptr_q];
	assign do_pop = pop && q_valid;
	assign q_stat.full = (count_q == CW'(DEPTH));
	assign q_stat.almost_full = (count_q >= CW'(DEPTH - 1));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/bvps_back.sv */
`timescale 1ns / 1ps
// Back end: shifts one cell out as eight pixels into the output register.
// Depends on bvps_pkg.
module bvps_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  bvps_pkg::cell_t q_cell,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output bvps_pkg::out_t  out_data
);
	import bvps_pkg::*;

	logic [PIXELS_PER_CELL-1:0] bits_q;
	logic [3:0]       color_q;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;
	logic             out_valid_q;
	out_t             out_q;
	logic             adv, emit, is_last;

	assign adv = !out_valid_q || !out_stall;
	assign emit = adv && busy_q;
	assign is_last = (idx_q == IDX_W'(PIXELS_PER_CELL - 1));
	// next cell loads while its predecessor's last pixel goes out
	assign pop = q_valid && (!busy_q || (emit && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (emit) begin
				busy_q <= !is_last;
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= make_pixel(color_q, bits_q[PIXELS_PER_CELL-1], is_last);
		end
		if (pop) begin
			bits_q <= q_cell.pixels;
			color_q <= q_cell.color;
		end else if (emit) begin
			bits_q <= {bits_q[PIXELS_PER_CELL-2:0], 1'b0};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

/* hdl/bitmap_video_pixel_shifter.sv */
`timescale 1ns / 1ps
// Top level of the bitmap video pixel shifter.
// Depends on bvps_pkg, bvps_front, bvps_queue, bvps_back.
//
// Input channel (in_valid / in_stall / in_data) takes video writes, color map
// writes and cell renders. Writes give no output.
// A render reads one pixel byte and one color byte, then the cell is put in
// a small queue; the shifter emits its eight pixels on the output channel
// (out_valid / out_stall / out_data), last_pixel marking the eighth.
// A render passes the RAM read registers, the queue and the shift register
// before its first pixel reaches the output register. Throughput: one pixel
// per cycle while out_stall is low; the pixel shift register sets the render
// rate. Writes and bursts of up to QUEUE_DEPTH + 1 renders into an idle block
// go in at one per cycle. When the receiver stalls, the output register holds
// its pixel; once the queue fills, in_stall rises and items wait at the input.
// cfg_we writes a register (bank low, bank high, flip) at once; write it only
// while no render is pending. Reset clears the registers and all control
// state; memory contents are undefined until written.
module bitmap_video_pixel_shifter #(
	parameter int QUEUE_DEPTH = bvps_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  bvps_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output bvps_pkg::out_t                 out_data,
	input  logic                           cfg_we,
	input  logic [bvps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bvps_pkg::CFG_W-1:0]     cfg_data
);
	import bvps_pkg::*;

	q_stat_t q_stat;
	logic    push, pop, q_valid;
	cell_t   push_cell, q_cell;

	bvps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_cell (push_cell)
	);

	bvps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cell (push_cell),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_cell    (q_cell),
		.q_stat    (q_stat)
	);

	bvps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cell    (q_cell),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

/* hdl/bvps_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the pixel shifter, bound to the top level.
// Depends on bvps_pkg and bitmap_video_pixel_shifter_assert.svh.
`include "bitmap_video_pixel_shifter_assert.svh"

module bvps_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_stall,
	input bvps_pkg::out_t out_data
);
	import bvps_pkg::*;

	`BVPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled pixel changed")

	// pixels of one cell leave back to back
	`BVPS_ASSERT_NEXT(a_cell_contig, out_valid && !out_stall && !out_data.last_pixel, out_valid, "gap inside a cell")

	`BVPS_ASSERT_NOW(a_rgb, out_valid, out_data == make_pixel(out_data.pen, 1'b1, out_data.last_pixel), "pen and RGB disagree")

endmodule

bind bitmap_video_pixel_shifter bvps_checker u_bvps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
